/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk_i outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/core/hst_pkg.sv */
`default_nettype none
package hst_pkg;

  localparam int unsigned MAX_POINTS = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int unsigned MUL_AW = 64;
  localparam int unsigned MUL_BW = 34;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
  localparam int unsigned MUL_NW = 6;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] val;
    logic [31:0] slope;
  } point_t;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADSLOT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CK,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_RM_RD,
    S_RM_WR,
    S_DIV,
    S_WGT,
    S_MUL_GO,
    S_MUL_WAIT
  } state_e;

  typedef enum logic [2:0] {
    MOP_EXT,
    MOP_F8,
    MOP_F9,
    MOP_FM,
    MOP_DY,
    MOP_MW
  } mop_e;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
    logic [MUL_NW-1:0] nb;
  } mul_req_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/hermite_spline_table_sampler.sv */
// Mode 3, an insert into a full table, a remove at a bad slot and a sample of an empty table
// give the result beat in the cycle after the accepting edge. Remove moves the points above
// slot s down by one. Insert scans for slot k, moves the entries from k up and writes the point.
// Sample scans for the interval, then extrapolates with one shift-add multiply, or runs the
// divider, a weight step and five shift-add multiplies to interpolate. One item at a time;
// next start taken in the beat cycle; receiver cannot stall; reset clears state, count, done.
`default_nettype none
`include "assert_macros.svh"
module hermite_spline_table_sampler import hst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode_i,
  input  wire logic [31:0] position_i,
  input  wire logic [31:0] point_value_i,
  input  wire logic [31:0] point_slope_i,
  input  wire logic [3:0]  remove_slot_i,
  output logic             done_o,
  output logic [31:0]      sample_value_o,
  output logic [3:0]       slot_o,
  output logic [1:0]       status_o,
  output logic [4:0]       count_o
);

  state_e state_q, state_d;
  mop_e   mop_q, mop_d;
  mode_e  mode_q, mode_d;

  logic [31:0]       t_q, t_d;
  logic [31:0]       nval_q, nval_d;
  logic [31:0]       nslope_q, nslope_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  point_t            p0_q, p0_d;
  point_t            p1_q, p1_d;
  logic [33:0]       dr_q, dr_d;
  logic [16:0]       dq_q, dq_d;
  logic [4:0]        dstep_q, dstep_d;
  logic [15:0]       u_q, u_d;
  logic [15:0]       w_q, w_d;
  logic signed [63:0] f8_q, f8_d;
  logic signed [63:0] mix_q, mix_d;
  logic signed [63:0] acc_q, acc_d;
  logic [31:0]       val_q, val_d;
  logic [3:0]        slot_q, slot_d;
  logic [1:0]        status_q, status_d;
  logic              done_q, done_d;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  point_t            mem_wdata, mem_rdata;
  mul_req_t          mul_req;
  logic [MUL_PW-1:0] mul_prod;
  logic              mul_done;

  // Shared datapath terms.
  logic [32:0]        dpos;
  logic signed [63:0] dy, y0, ps;
  logic signed [MUL_PW-1:0] prod_sh;
  logic [33:0]        tdiff;
  logic               scan_end, scan_go, tbl_full, slot_bad;
  logic [33:0]        div_rr;
  logic               div_ge;
  logic [15:0]        u_c;
  logic [32:0]        uw;

  always_comb begin
    dpos     = 33'({p1_q.pos[31], p1_q.pos} - {p0_q.pos[31], p0_q.pos});
    dy       = 64'($signed(p1_q.val)) - 64'($signed(p0_q.val));
    y0       = 64'($signed(p0_q.val));
    prod_sh  = $signed(mul_prod) >>> 16;
    ps       = prod_sh[63:0];
    tdiff    = {t_q[31], t_q[31], t_q} - {p0_q.pos[31], p0_q.pos[31], p0_q.pos};
    scan_end = (idx_q == cnt_q);
    // Sample stops at the first point at or past t; insert goes after equal positions.
    scan_go  = (mode_q == MODE_SAMPLE) ? ($signed(mem_rdata.pos) < $signed(t_q))
                                       : ($signed(mem_rdata.pos) <= $signed(t_q));
    tbl_full = (cnt_q >= CNT_W'(MAX_POINTS));
    slot_bad = (CNT_W'(remove_slot_i) >= cnt_q);
    div_rr   = (dstep_q == 5'd0) ? dr_q : {dr_q[32:0], 1'b0};
    div_ge   = (div_rr >= {1'b0, dpos});
    u_c      = (dq_q > 17'h0FFFF) ? 16'hFFFF : dq_q[15:0];
    uw       = 33'(u_c) * (33'h10000 - 33'(u_c));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (mode_e'(mode_i))
            MODE_SAMPLE: state_d = (cnt_q == '0) ? S_IDLE : S_SCAN_RD;
            MODE_INSERT: state_d = tbl_full ? S_IDLE : S_SCAN_RD;
            MODE_REMOVE: state_d = slot_bad ? S_IDLE : S_RM_RD;
            MODE_NONE:   state_d = S_IDLE;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (!scan_end) begin
          state_d = S_SCAN_CK;
        end else begin
          state_d = (mode_q == MODE_SAMPLE) ? S_MUL_GO : S_SH_RD;
        end
      end
      S_SCAN_CK: begin
        if (scan_go) begin
          state_d = S_SCAN_RD;
        end else if (mode_q != MODE_SAMPLE) begin
          state_d = S_SH_RD;
        end else begin
          state_d = (idx_q == '0) ? S_MUL_GO : S_DIV;
        end
      end
      S_SH_RD:    state_d = (idx_q > k_q) ? S_SH_WR : S_INS_WR;
      S_SH_WR:    state_d = S_SH_RD;
      S_INS_WR:   state_d = S_IDLE;
      S_RM_RD:    state_d = (idx_q + CNT_W'(1) < cnt_q) ? S_RM_WR : S_IDLE;
      S_RM_WR:    state_d = S_RM_RD;
      S_DIV:      state_d = (dstep_q == 5'd16) ? S_WGT : S_DIV;
      S_WGT:      state_d = S_MUL_GO;
      S_MUL_GO:   state_d = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mul_done) begin
          state_d = (mop_q == MOP_EXT || mop_q == MOP_MW) ? S_IDLE : S_MUL_GO;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    mop_d     = mop_q;
    mode_d    = mode_q;
    t_d       = t_q;
    nval_d    = nval_q;
    nslope_d  = nslope_q;
    idx_d     = idx_q;
    k_d       = k_q;
    cnt_d     = cnt_q;
    p0_d      = p0_q;
    p1_d      = p1_q;
    dr_d      = dr_q;
    dq_d      = dq_q;
    dstep_d   = dstep_q;
    u_d       = u_q;
    w_d       = w_q;
    f8_d      = f8_q;
    mix_d     = mix_q;
    acc_d     = acc_q;
    val_d     = val_q;
    slot_d    = slot_q;
    status_d  = status_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_q[IDX_W-1:0];
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_q[IDX_W-1:0];
    mul_req   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_d   = mode_e'(mode_i);
          t_d      = position_i;
          nval_d   = point_value_i;
          nslope_d = point_slope_i;
          idx_d    = (mode_e'(mode_i) == MODE_REMOVE) ? CNT_W'(remove_slot_i) : '0;
          val_d    = '0;
          slot_d   = '0;
          status_d = ST_OK;
          // Answer at once when nothing needs the table.
          unique case (mode_e'(mode_i))
            MODE_SAMPLE: done_d = (cnt_q == '0);
            MODE_INSERT: begin
              done_d   = tbl_full;
              status_d = tbl_full ? ST_FULL : ST_OK;
            end
            MODE_REMOVE: begin
              done_d   = slot_bad;
              status_d = slot_bad ? ST_BADSLOT : ST_OK;
            end
            MODE_NONE:   done_d = 1'b1;
            default:     done_d = 1'b1;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (!scan_end) begin
          mem_re = 1'b1;
        end else if (mode_q == MODE_SAMPLE) begin
          mop_d = MOP_EXT;   // past the last point: p0 holds it
        end else begin
          k_d = idx_q;
        end
      end
      S_SCAN_CK: begin
        if (scan_go) begin
          p0_d  = mem_rdata;
          idx_d = idx_q + CNT_W'(1);
        end else if (mode_q != MODE_SAMPLE) begin
          k_d   = idx_q;
          idx_d = cnt_q;
        end else if (idx_q == '0) begin
          p0_d  = mem_rdata;
          mop_d = MOP_EXT;
        end else begin
          p1_d    = mem_rdata;
          dr_d    = tdiff;
          dq_d    = '0;
          dstep_d = '0;
        end
      end
      S_SH_RD: begin
        if (idx_q > k_q) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(idx_q - CNT_W'(1));
        end
      end
      S_SH_WR: begin
        // Move entry up by one; next read is two entries lower, never this one.
        mem_we = 1'b1;
        idx_d  = idx_q - CNT_W'(1);
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_q[IDX_W-1:0];
        mem_wdata = '{pos: t_q, val: nval_q, slope: nslope_q};
        cnt_d     = cnt_q + CNT_W'(1);
        slot_d    = 4'(k_q);
        done_d    = 1'b1;
      end
      S_RM_RD: begin
        if (idx_q + CNT_W'(1) < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(idx_q + CNT_W'(1));
        end else begin
          cnt_d  = cnt_q - CNT_W'(1);
          done_d = 1'b1;
        end
      end
      S_RM_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + CNT_W'(1);
      end
      S_DIV: begin
        // One quotient bit per cycle of (t - x0) * 2^16 / (x1 - x0).
        if (div_ge) begin
          dr_d = div_rr - {1'b0, dpos};
          dq_d = {dq_q[15:0], 1'b1};
        end else begin
          dr_d = div_rr;
          dq_d = {dq_q[15:0], 1'b0};
        end
        dstep_d = dstep_q + 5'd1;
      end
      S_WGT: begin
        u_d   = u_c;
        w_d   = uw[31:16];
        mop_d = MOP_F8;
      end
      S_MUL_GO: begin
        mul_req.start = 1'b1;
        unique case (mop_q)
          MOP_EXT: begin
            mul_req.a  = 64'($signed(p0_q.slope));
            mul_req.b  = tdiff;
            mul_req.nb = MUL_NW'(34);
          end
          MOP_F8: begin
            mul_req.a  = 64'($signed(p0_q.slope));
            mul_req.b  = {1'b0, dpos};
            mul_req.nb = MUL_NW'(34);
          end
          MOP_F9: begin
            mul_req.a  = 64'($signed(p1_q.slope));
            mul_req.b  = {1'b0, dpos};
            mul_req.nb = MUL_NW'(34);
          end
          MOP_FM: begin
            mul_req.a  = mix_q;
            mul_req.b  = 34'(u_q);
            mul_req.nb = MUL_NW'(17);
          end
          MOP_DY: begin
            mul_req.a  = dy;
            mul_req.b  = 34'(u_q);
            mul_req.nb = MUL_NW'(17);
          end
          MOP_MW: begin
            mul_req.a  = mix_q;
            mul_req.b  = 34'(w_q);
            mul_req.nb = MUL_NW'(17);
          end
          default: mul_req.nb = MUL_NW'(17);
        endcase
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          unique case (mop_q)
            MOP_EXT: begin
              val_d  = sat32(y0 + ps);
              done_d = 1'b1;
            end
            MOP_F8: begin
              f8_d  = ps - dy;
              mop_d = MOP_F9;
            end
            MOP_F9: begin
              mix_d = (dy - ps) - f8_q;  // hold f9 - f8
              mop_d = MOP_FM;
            end
            MOP_FM: begin
              mix_d = f8_q + ps;
              mop_d = MOP_DY;
            end
            MOP_DY: begin
              acc_d = y0 + ps;
              mop_d = MOP_MW;
            end
            MOP_MW: begin
              val_d  = sat32(acc_q + ps);
              done_d = 1'b1;
            end
            default: mop_d = MOP_EXT;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mop_q    <= mop_d;
    mode_q   <= mode_d;
    t_q      <= t_d;
    nval_q   <= nval_d;
    nslope_q <= nslope_d;
    idx_q    <= idx_d;
    k_q      <= k_d;
    p0_q     <= p0_d;
    p1_q     <= p1_d;
    dr_q     <= dr_d;
    dq_q     <= dq_d;
    dstep_q  <= dstep_d;
    u_q      <= u_d;
    w_q      <= w_d;
    f8_q     <= f8_d;
    mix_q    <= mix_d;
    acc_q    <= acc_d;
    val_q    <= val_d;
    slot_q   <= slot_d;
    status_q <= status_d;
  end

  hst_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  hst_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .prod_o (mul_prod),
    .done_o (mul_done)
  );

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign sample_value_o = val_q;
  assign slot_o         = slot_q;
  assign status_o       = status_q;
  assign count_o        = 5'(cnt_q);

  `ASSERT_CLK(a_cnt_max, cnt_q <= CNT_W'(MAX_POINTS), "point count above table depth")
  `ASSERT_NEVER(a_done_busy, done_o && busy, "result beat while still busy")
  `ASSERT_CLK(a_none_fast, start && !busy && mode_i == MODE_NONE |=> done_o, "unused mode slow")
  `ASSERT_CLK(a_cnt_beat, !$stable(count_o) |-> done_o, "count moved without a result beat")
  `ASSERT_NEVER(a_mem_clash, mem_we && mem_re && mem_waddr == mem_raddr, "same entry read and written")

endmodule
`default_nettype wire

/* rtl/core/hst_mem.sv */
`default_nettype none
module hst_mem import hst_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire point_t           wdata_i,
  input  wire logic             re_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output point_t                rdata_o
);

  point_t mem_q [MAX_POINTS];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/hst_mul.sv */
`default_nettype none
module hst_mul import hst_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mul_req_t          req_i,
  output logic [MUL_PW-1:0]      prod_o,
  output logic                   done_o
);

  // Shift-add over the multiplier bits, low bit first; the top bit weighs negative.
  logic                     run_q, run_d;
  logic                     done_q, done_d;
  logic signed [MUL_PW-1:0] am_q, am_d;
  logic [MUL_BW-1:0]        bm_q, bm_d;
  logic signed [MUL_PW-1:0] acc_q, acc_d;
  logic [MUL_NW-1:0]        step_q, step_d;
  logic [MUL_NW-1:0]        nb_q, nb_d;
  logic signed [MUL_PW-1:0] addend;
  logic                     last;

  always_comb begin
    last   = (step_q == nb_q - MUL_NW'(1));
    addend = '0;
    if (bm_q[0]) begin
      addend = last ? -am_q : am_q;
    end
    run_d  = run_q;
    done_d = 1'b0;
    am_d   = am_q;
    bm_d   = bm_q;
    acc_d  = acc_q;
    step_d = step_q;
    nb_d   = nb_q;
    if (req_i.start) begin
      run_d  = 1'b1;
      am_d   = MUL_PW'($signed(req_i.a));
      bm_d   = req_i.b;
      acc_d  = '0;
      step_d = '0;
      nb_d   = req_i.nb;
    end else if (run_q) begin
      acc_d  = acc_q + addend;
      am_d   = am_q <<< 1;
      bm_d   = bm_q >> 1;
      step_d = step_q + MUL_NW'(1);
      if (last) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    am_q   <= am_d;
    bm_q   <= bm_d;
    acc_q  <= acc_d;
    step_q <= step_d;
    nb_q   <= nb_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule
`default_nettype wire
